/* rtl/lmc_pkg.sv */
`default_nettype none

package lmc_pkg;

	typedef enum logic [1:0] {
		OP_POWER  = 2'd0,
		OP_SAMPLE = 2'd1,
		OP_TICK   = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		REG_LEVEL_MOON    = 3'd0,
		REG_LEVEL_LOW     = 3'd1,
		REG_LEVEL_MED     = 3'd2,
		REG_LEVEL_HIGH    = 3'd3,
		REG_LEVEL_HIGHER  = 3'd4,
		REG_LOW_THRESHOLD = 3'd5,
		REG_CRIT_THRESHOLD = 3'd6,
		REG_SAVE_DELAY    = 3'd7
	} cfg_reg_t;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 10;

	localparam logic [3:0] MODE_LOWEST = 4'd0;
	localparam logic [3:0] SOLID_END   = 4'd5;
	localparam logic [3:0] DUAL_END    = 4'd8;
	localparam logic [3:0] SINGLE_MODE = 4'd8;
	localparam logic [3:0] BATT_MODE   = 4'd9;

	localparam logic [7:0] EMPTY_BYTE  = 8'd255;
	localparam logic [1:0] LOW_SAMPLES = 2'd3;
	localparam logic [9:0] HOLD_TIME   = 10'd1000;
	localparam logic [9:0] TIMER_MAX   = 10'd1023;

	localparam logic [12:0] BEACON_CYCLE  = 13'd1000;
	localparam logic [12:0] FLASH_PERIOD  = 13'd70;
	localparam logic [12:0] FLASH_ON      = 13'd5;
	localparam int unsigned FLASH_COUNT   = 4;
	localparam logic [12:0] SINGLE_SECOND = 13'd250;
	localparam logic [12:0] BATT_DARK     = 13'd1000;
	localparam logic [12:0] BLINK_PERIOD  = 13'd500;
	localparam logic [12:0] BLINK_ON      = 13'd100;
	localparam logic [12:0] BATT_TAIL     = 13'd1000;
	localparam int unsigned BATT_STEPS    = 5;

	localparam logic [7:0] BATT_LEVELS [BATT_STEPS] = '{
		8'd139, 8'd154, 8'd164, 8'd174, 8'd184
	};

	typedef struct packed {
		logic [7:0] level_moon;
		logic [7:0] level_low;
		logic [7:0] level_med;
		logic [7:0] level_high;
		logic [7:0] level_higher;
		logic [7:0] low_threshold;
		logic [7:0] critical_threshold;
		logic [9:0] save_delay;
	} cfg_t;

	typedef struct packed {
		logic [3:0]  mode_now;
		logic [1:0]  low_count;
		logic [12:0] phase_ms;
		logic [2:0]  blink_total;
		logic [7:0]  last_voltage;
		logic [9:0]  save_timer;
		logic        saved_done;
		logic        is_off;
		logic [9:0]  hold_ms;
	} state_t;

	typedef struct packed {
		logic       shut_off;
		logic [7:0] save_value;
		logic       save_request;
		logic [3:0] mode_index;
		logic [7:0] pwm_level;
	} result_t;

	// Battery check cycle length for a given number of blinks.
	function automatic logic [12:0] batt_cycle(input logic [2:0] blinks);
		logic [12:0] len;
		case (blinks)
			3'd0:    len = BATT_DARK + BATT_TAIL;
			3'd1:    len = BATT_DARK + BATT_TAIL + BLINK_PERIOD;
			3'd2:    len = BATT_DARK + BATT_TAIL + 13'd2 * BLINK_PERIOD;
			3'd3:    len = BATT_DARK + BATT_TAIL + 13'd3 * BLINK_PERIOD;
			3'd4:    len = BATT_DARK + BATT_TAIL + 13'd4 * BLINK_PERIOD;
			default: len = BATT_DARK + BATT_TAIL + 13'd5 * BLINK_PERIOD;
		endcase
		return len;
	endfunction

endpackage

`default_nettype wire

/* rtl/lmc_step.sv */
`default_nettype none

module lmc_step (
	input  wire lmc_pkg::cfg_t    cfg,
	input  wire lmc_pkg::state_t  st,
	input  wire lmc_pkg::op_t     op,
	input  wire logic [7:0]       stored_byte,
	input  wire logic [7:0]       voltage,
	output lmc_pkg::state_t       st_next,
	output lmc_pkg::result_t      res
);

	function automatic logic [7:0] solid_level(input lmc_pkg::cfg_t c, input logic [3:0] m);
		logic [7:0] lvl;
		case (m)
			4'd0:    lvl = c.level_moon;
			4'd1:    lvl = c.level_low;
			4'd2:    lvl = c.level_med;
			4'd3:    lvl = c.level_high;
			4'd4:    lvl = c.level_higher;
			default: lvl = 8'd0;
		endcase
		return lvl;
	endfunction

	logic [6:0]  mode_raw;
	logic [3:0]  power_mode;
	logic [7:0]  thr;
	logic [2:0]  cnt;
	logic [9:0]  timer;
	logic [13:0] next_phase;
	logic [12:0] clen;
	logic [2:0]  blinks;
	logic [12:0] p;
	logic [12:0] q;
	logic        flash;
	logic        blink_on;
	logic [7:0]  level;
	logic        save_req;
	logic [7:0]  save_val;

	always_comb begin
		blinks = 3'd0;
		for (int i = 0; i < lmc_pkg::BATT_STEPS; i++) begin
			if (st.last_voltage > lmc_pkg::BATT_LEVELS[i]) begin
				blinks = blinks + 3'd1;
			end
		end
	end

	always_comb begin
		mode_raw = {1'b0, stored_byte[5:0]} + {6'd0, stored_byte[6]};
		if (stored_byte == lmc_pkg::EMPTY_BYTE || mode_raw > {3'd0, lmc_pkg::BATT_MODE}) begin
			power_mode = lmc_pkg::MODE_LOWEST;
		end else begin
			power_mode = mode_raw[3:0];
		end
	end

	always_comb begin
		if (st.mode_now < lmc_pkg::SOLID_END) begin
			clen = 13'd1;
		end else if (st.mode_now < lmc_pkg::BATT_MODE) begin
			clen = lmc_pkg::BEACON_CYCLE;
		end else begin
			clen = lmc_pkg::batt_cycle(st.blink_total);
		end
	end

	always_comb begin
		st_next = st;
		save_req = 1'b0;
		save_val = 8'd0;
		thr = (st.mode_now == lmc_pkg::MODE_LOWEST) ? cfg.critical_threshold : cfg.low_threshold;
		cnt = (voltage < thr) ? {1'b0, st.low_count} + 3'd1 : 3'd0;
		timer = (st.save_timer < lmc_pkg::TIMER_MAX) ? st.save_timer + 10'd1 : st.save_timer;
		next_phase = {1'b0, st.phase_ms} + 14'd1;
		if (next_phase >= {1'b0, clen}) begin
			next_phase = 14'd0;
		end
		case (op)
			lmc_pkg::OP_POWER: begin
				st_next.mode_now = power_mode;
				st_next.low_count = 2'd0;
				st_next.phase_ms = 13'd0;
				st_next.blink_total = 3'd0;
				st_next.hold_ms = 10'd0;
				st_next.save_timer = 10'd0;
				st_next.saved_done = 1'b0;
				st_next.is_off = 1'b0;
				save_req = 1'b1;
				save_val = {4'd0, power_mode} | 8'h40;
			end
			lmc_pkg::OP_SAMPLE: begin
				if (!st.is_off && st.hold_ms == 10'd0) begin
					st_next.last_voltage = voltage;
					st_next.low_count = cnt[1:0];
					if (cnt >= {1'b0, lmc_pkg::LOW_SAMPLES}) begin
						st_next.low_count = 2'd0;
						if (st.mode_now == lmc_pkg::MODE_LOWEST) begin
							st_next.is_off = 1'b1;
						end else begin
							if (st.mode_now == lmc_pkg::SINGLE_MODE ||
							    st.mode_now == lmc_pkg::SOLID_END) begin
								st_next.mode_now = lmc_pkg::MODE_LOWEST;
							end else begin
								st_next.mode_now = st.mode_now - 4'd1;
							end
							st_next.hold_ms = lmc_pkg::HOLD_TIME;
							st_next.phase_ms = 13'd0;
							st_next.blink_total = 3'd0;
						end
					end
				end
			end
			lmc_pkg::OP_TICK: begin
				if (!st.is_off) begin
					if (!st.saved_done) begin
						st_next.save_timer = timer;
						if (timer >= cfg.save_delay) begin
							st_next.saved_done = 1'b1;
							save_req = 1'b1;
							save_val = {4'd0, st.mode_now};
						end
					end
					if (st.hold_ms != 10'd0) begin
						st_next.hold_ms = st.hold_ms - 10'd1;
					end else begin
						st_next.phase_ms = next_phase[12:0];
						if (st.mode_now == lmc_pkg::BATT_MODE &&
						    next_phase[12:0] == lmc_pkg::BATT_DARK) begin
							st_next.blink_total = blinks;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		p = st_next.phase_ms;
		q = p - lmc_pkg::BATT_DARK;
		flash = 1'b0;
		for (int k = 0; k < lmc_pkg::FLASH_COUNT; k++) begin
			if (p >= 13'(k) * lmc_pkg::FLASH_PERIOD &&
			    p < 13'(k) * lmc_pkg::FLASH_PERIOD + lmc_pkg::FLASH_ON) begin
				flash = 1'b1;
			end
		end
		blink_on = 1'b0;
		for (int k = 0; k < lmc_pkg::BATT_STEPS; k++) begin
			if (3'(k) < st_next.blink_total &&
			    q >= 13'(k) * lmc_pkg::BLINK_PERIOD &&
			    q < 13'(k) * lmc_pkg::BLINK_PERIOD + lmc_pkg::BLINK_ON) begin
				blink_on = 1'b1;
			end
		end
		if (st_next.is_off) begin
			level = 8'd0;
		end else if (st_next.hold_ms != 10'd0) begin
			if (st_next.mode_now < lmc_pkg::SOLID_END) begin
				level = solid_level(cfg, st_next.mode_now);
			end else if (st_next.mode_now < lmc_pkg::DUAL_END) begin
				level = solid_level(cfg, st_next.mode_now - lmc_pkg::SOLID_END);
			end else begin
				level = 8'd0;
			end
		end else if (st_next.mode_now < lmc_pkg::SOLID_END) begin
			level = solid_level(cfg, st_next.mode_now);
		end else if (st_next.mode_now < lmc_pkg::DUAL_END) begin
			if (flash) begin
				level = solid_level(cfg, st_next.mode_now - 4'd3);
			end else begin
				level = solid_level(cfg, st_next.mode_now - lmc_pkg::SOLID_END);
			end
		end else if (st_next.mode_now == lmc_pkg::SINGLE_MODE) begin
			level = (p == 13'd0 || p == lmc_pkg::SINGLE_SECOND) ? cfg.level_higher : 8'd0;
		end else if (p < lmc_pkg::BATT_DARK) begin
			level = 8'd0;
		end else begin
			level = blink_on ? cfg.level_med : 8'd0;
		end
		res.pwm_level = level;
		res.mode_index = st_next.mode_now;
		res.save_request = save_req;
		res.save_value = save_val;
		res.shut_off = st_next.is_off;
	end

endmodule

`default_nettype wire

/* rtl/light_mode_controller.sv */
// A request waits in the event register, then its result is loaded into the output register.
// Throughput: one request per cycle; the event register and the result register each take
// a new request whenever the stage after them is free or being emptied in the same cycle.
// Reset: arst_n clears all control state and loads the register defaults; the light starts dark
// with shut_off set until the first power-on request.
`default_nettype none

module light_mode_controller (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,  // stored_byte, voltage
	input  wire logic [1:0]  s_axis_tuser,  // op
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// pwm_level, mode_index, save_request, save_value, shut_off, zero fill
	output logic [23:0]      m_axis_tdata,
	input  wire logic        cfg_we,
	input  wire logic [lmc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [lmc_pkg::CFG_DATA_W-1:0]  cfg_data
);

	lmc_pkg::cfg_t    cfg_q;
	lmc_pkg::state_t  st_q;
	lmc_pkg::state_t  st_next;
	lmc_pkg::result_t res;
	lmc_pkg::result_t out_q;
	lmc_pkg::op_t     op_s1;
	logic [7:0]       stored_byte_s1;
	logic [7:0]       voltage_s1;
	logic             valid_s1;
	logic             out_valid_q;
	logic             adv;

	assign adv = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {2'b00, out_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.level_moon <= 8'd6;
			cfg_q.level_low <= 8'd14;
			cfg_q.level_med <= 8'd39;
			cfg_q.level_high <= 8'd120;
			cfg_q.level_higher <= 8'd255;
			cfg_q.low_threshold <= 8'd123;
			cfg_q.critical_threshold <= 8'd113;
			cfg_q.save_delay <= 10'd1000;
		end else if (cfg_we) begin
			unique case (lmc_pkg::cfg_reg_t'(cfg_index))
				lmc_pkg::REG_LEVEL_MOON:     cfg_q.level_moon <= cfg_data[7:0];
				lmc_pkg::REG_LEVEL_LOW:      cfg_q.level_low <= cfg_data[7:0];
				lmc_pkg::REG_LEVEL_MED:      cfg_q.level_med <= cfg_data[7:0];
				lmc_pkg::REG_LEVEL_HIGH:     cfg_q.level_high <= cfg_data[7:0];
				lmc_pkg::REG_LEVEL_HIGHER:   cfg_q.level_higher <= cfg_data[7:0];
				lmc_pkg::REG_LOW_THRESHOLD:  cfg_q.low_threshold <= cfg_data[7:0];
				lmc_pkg::REG_CRIT_THRESHOLD: cfg_q.critical_threshold <= cfg_data[7:0];
				lmc_pkg::REG_SAVE_DELAY:     cfg_q.save_delay <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_s1 <= lmc_pkg::op_t'(s_axis_tuser);
			stored_byte_s1 <= s_axis_tdata[7:0];
			voltage_s1 <= s_axis_tdata[15:8];
		end
	end

	lmc_step u_step (
		.cfg         (cfg_q),
		.st          (st_q),
		.op          (op_s1),
		.stored_byte (stored_byte_s1),
		.voltage     (voltage_s1),
		.st_next     (st_next),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.mode_now <= 4'd0;
			st_q.low_count <= 2'd0;
			st_q.phase_ms <= 13'd0;
			st_q.blink_total <= 3'd0;
			st_q.last_voltage <= 8'd0;
			st_q.save_timer <= 10'd0;
			st_q.saved_done <= 1'b1;
			st_q.is_off <= 1'b1;
			st_q.hold_ms <= 10'd0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			st_q <= st_next;
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= res;
		end
	end

`ifndef ASSERT_OFF
	a_power_on: assert property (@(posedge clk) disable iff (!arst_n)
		adv && op_s1 == lmc_pkg::OP_POWER |=> !st_q.is_off && st_q.mode_now <= lmc_pkg::BATT_MODE)
		else $error("power-on request did not leave the light on in a legal mode");
	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid_q)
		else $error("processed request produced no result");
	a_off_tick: assert property (@(posedge clk) disable iff (!arst_n)
		adv && op_s1 == lmc_pkg::OP_TICK && st_q.is_off |=> $stable(st_q))
		else $error("tick changed state while the light was off");
	a_off_dark: assert property (@(posedge clk) disable iff (!arst_n)
		adv && st_next.is_off |=> out_q.pwm_level == 8'd0 && out_q.shut_off)
		else $error("light reported on while shut off");
`endif

endmodule

`default_nettype wire
